### rtl/ecr_pkg.sv
// Package for the ultrasonic echo ranger: register reset values, arithmetic constants,
// register index codes and the structs passed between pipeline stages.
// Used by every module in rtl/.
package ecr_pkg;

	localparam int CountW = 16;
	localparam int TrigW = 8;
	localparam int MmW = 13;
	localparam int CmW = 10;
	localparam int ScaledW = 18;

	localparam logic [CountW-1:0] TIMEOUT_RST = 16'd35000;
	localparam logic [TrigW-1:0] TRIG_WIDTH_RST = 8'd10;
	localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

	// Durations above this value all give the saturated distance of 8191 mm.
	localparam logic [CountW-1:0] T_CLAMP = 16'd47510;
	localparam logic [ScaledW-1:0] SCALE_OFFSET = 18'd14;

	// x / 29 as (x * DIV29_MUL) >> DIV29_SHIFT, exact for x below 2^18.
	localparam int Div29MulW = 19;
	localparam logic [Div29MulW-1:0] DIV29_MUL = 19'd289263;
	localparam int DIV29_SHIFT = 23;

	// y / 10 as (y * DIV10_MUL) >> DIV10_SHIFT, exact for y below 2^14.
	localparam int Div10MulW = 15;
	localparam int CmSumW = 14;
	localparam logic [Div10MulW-1:0] DIV10_MUL = 15'd26215;
	localparam int DIV10_SHIFT = 18;
	localparam logic [CmSumW-1:0] CM_ROUND = 14'd5;

	localparam int AddrW = 3;
	localparam int DataW = 32;
	localparam logic REG_ECHO_TIMEOUT = 1'b0;
	localparam logic REG_TRIGGER_WIDTH = 1'b1;

	typedef struct packed {
		logic trig;
		logic ready;
		logic meas;
	} tick_ctl_t;

	typedef struct packed {
		logic fresh;
		logic out_of_range;
		logic [ScaledW-1:0] scaled;
	} dist_req_t;

endpackage

### rtl/ecr_front.sv
// Input register and tick state of the echo ranger: trigger pulse counter, echo edge
// detection, elapsed-time counter and ready flag. Depends on ecr_pkg.
module ecr_front
	import ecr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_s1,
	input  logic              ld_s2,
	input  logic              echo_level,
	input  logic              start_request,
	input  logic              ready_ack,
	input  logic [CountW-1:0] echo_timeout_us,
	input  logic [TrigW-1:0]  trigger_width_us,
	output tick_ctl_t         ctl_s2,
	output dist_req_t         req_s2
);

	logic echo_s1;
	logic start_s1;
	logic ack_s1;

	logic              echo_prev_q;
	logic              active_q;
	logic [CountW-1:0] elapsed_q;
	logic              ready_q;
	logic [TrigW-1:0]  pulse_q;

	logic [TrigW-1:0]  pulse_load;
	logic              trig;
	logic              rise;
	logic              fresh;
	logic              active_next;
	logic [CountW-1:0] elapsed_inc;
	logic [CountW-1:0] elapsed_next;
	logic [CountW-1:0] t_clamped;
	logic [ScaledW-1:0] scaled;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			echo_s1 <= echo_level;
			start_s1 <= start_request;
			ack_s1 <= ready_ack;
		end
	end

	always_comb begin
		pulse_load = start_s1 ? trigger_width_us : pulse_q;
		trig = (pulse_load != '0);
		rise = echo_s1 && !echo_prev_q;
		elapsed_inc = (elapsed_q < COUNT_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		fresh = 1'b0;
		active_next = active_q;
		elapsed_next = elapsed_q;
		if (rise) begin
			elapsed_next = '0;
			active_next = 1'b1;
		end else if (active_q) begin
			elapsed_next = elapsed_inc;
			if (!echo_s1) begin
				active_next = 1'b0;
				fresh = 1'b1;
			end
		end
		t_clamped = (elapsed_next > T_CLAMP) ? T_CLAMP : elapsed_next;
		scaled = {t_clamped, 2'b00} + {2'b00, t_clamped} + SCALE_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q <= 1'b0;
			active_q <= 1'b0;
			elapsed_q <= '0;
			ready_q <= 1'b0;
			pulse_q <= '0;
		end else if (ld_s2) begin
			echo_prev_q <= echo_s1;
			active_q <= active_next;
			elapsed_q <= elapsed_next;
			pulse_q <= trig ? pulse_load - 1'b1 : pulse_load;
			if (fresh) begin
				ready_q <= 1'b1;
			end else if (ack_s1) begin
				ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			ctl_s2.trig <= trig;
			ctl_s2.ready <= fresh || ready_q;
			ctl_s2.meas <= active_next;
			req_s2.fresh <= fresh;
			req_s2.out_of_range <= (elapsed_next >= echo_timeout_us);
			req_s2.scaled <= scaled;
		end
	end

endmodule

### rtl/ecr_dist.sv
// Distance stage of the echo ranger: divides the scaled echo time by 29 and holds the
// last measured distance in millimeters. Depends on ecr_pkg.
module ecr_dist
	import ecr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld_s3,
	input  tick_ctl_t      ctl_s2,
	input  dist_req_t      req_s2,
	output tick_ctl_t      ctl_s3,
	output logic [MmW-1:0] mm_s3
);

	logic [ScaledW+Div29MulW-1:0] product;
	logic [MmW-1:0]               quotient;

	always_comb begin
		product = {{Div29MulW{1'b0}}, req_s2.scaled} * {{ScaledW{1'b0}}, DIV29_MUL};
		quotient = product[DIV29_SHIFT +: MmW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_s3 <= '0;
		end else if (ld_s3 && req_s2.fresh) begin
			mm_s3 <= req_s2.out_of_range ? '0 : quotient;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

### rtl/ecr_out.sv
// Output register of the echo ranger: converts millimeters to rounded centimeters and
// holds the result word until it is taken. Depends on ecr_pkg.
module ecr_out
	import ecr_pkg::*;
(
	input  logic           clk,
	input  logic           ld_s4,
	input  tick_ctl_t      ctl_s3,
	input  logic [MmW-1:0] mm_s3,
	output logic           trigger_out,
	output logic [MmW-1:0] range_mm,
	output logic [CmW-1:0] range_cm,
	output logic           result_ready,
	output logic           measuring
);

	logic [CmSumW-1:0]           rounded;
	logic [CmSumW+Div10MulW-1:0] product;

	always_comb begin
		rounded = {1'b0, mm_s3} + CM_ROUND;
		product = {{Div10MulW{1'b0}}, rounded} * {{CmSumW{1'b0}}, DIV10_MUL};
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			trigger_out <= ctl_s3.trig;
			range_mm <= mm_s3;
			range_cm <= product[DIV10_SHIFT +: CmW];
			result_ready <= ctl_s3.ready;
			measuring <= ctl_s3.meas;
		end
	end

endmodule

### rtl/ultrasonic_echo_ranger_core.sv
// Top level of the ultrasonic echo ranger: configuration registers, pipeline control and
// the three processing stages. Depends on ecr_pkg, ecr_front, ecr_dist and ecr_out.
//
// Each input word is one microsecond tick and produces exactly one result word. The block
// takes a word in every cycle unless tick_stall is high; a word passes in order through the
// input register, tick state update, division by 29, then centimeter conversion into the
// output register. A result-side stall reaches tick_stall combinationally through every
// full stage. Registers: echo_timeout_us at byte address 0, trigger_width_us at byte address 4.
module ultrasonic_echo_ranger_core
	import ecr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  logic             echo_level,
	input  logic             start_request,
	input  logic             ready_ack,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             trigger_out,
	output logic [MmW-1:0]   range_mm,
	output logic [CmW-1:0]   range_cm,
	output logic             result_ready,
	output logic             measuring
);

	logic [CountW-1:0] timeout_q;
	logic [TrigW-1:0]  trig_width_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;
	logic cfg_wr;

	tick_ctl_t      ctl_s2;
	tick_ctl_t      ctl_s3;
	dist_req_t      req_s2;
	logic [MmW-1:0] mm_s3;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			trig_width_q <= TRIG_WIDTH_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ECHO_TIMEOUT: timeout_q <= pwdata[CountW-1:0];
				REG_TRIGGER_WIDTH: trig_width_q <= pwdata[TrigW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ECHO_TIMEOUT: prdata = {{(DataW-CountW){1'b0}}, timeout_q};
			REG_TRIGGER_WIDTH: prdata = {{(DataW-TrigW){1'b0}}, trig_width_q};
			default: prdata = '0;
		endcase
	end

	assign rdy4 = !v_s4 || !result_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign tick_stall = !rdy1;
	assign result_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= tick_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	ecr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.ld_s1            (tick_valid && rdy1),
		.ld_s2            (v_s1 && rdy2),
		.echo_level       (echo_level),
		.start_request    (start_request),
		.ready_ack        (ready_ack),
		.echo_timeout_us  (timeout_q),
		.trigger_width_us (trig_width_q),
		.ctl_s2           (ctl_s2),
		.req_s2           (req_s2)
	);

	ecr_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ld_s3  (v_s2 && rdy3),
		.ctl_s2 (ctl_s2),
		.req_s2 (req_s2),
		.ctl_s3 (ctl_s3),
		.mm_s3  (mm_s3)
	);

	ecr_out u_out (
		.clk          (clk),
		.ld_s4        (v_s3 && rdy4),
		.ctl_s3       (ctl_s3),
		.mm_s3        (mm_s3),
		.trigger_out  (trigger_out),
		.range_mm     (range_mm),
		.range_cm     (range_cm),
		.result_ready (result_ready),
		.measuring    (measuring)
	);

endmodule

### tb/tb_ultrasonic_echo_ranger_core.sv
// Self-checking testbench for ultrasonic_echo_ranger_core: a directed table, then random echo
// pulses, each result word compared to a tick-by-tick model of the ranger or to a word fixed in
// the table. Depends on ecr_pkg and the RTL in rtl/; drives the APB port and both word channels.
module tb_ultrasonic_echo_ranger_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ecr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int RANDOM_PHASES = 5;
	localparam int DRAIN_CYCLES = 16;
	localparam int MM_CEIL = 8191;

	typedef struct packed {
		logic trig;
		logic [MmW-1:0] mm;
		logic [CmW-1:0] cm;
		logic rdy;
		logic meas;
	} range_word_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic echo;
		logic start;
		logic ack;
		int reps;
		bit typed;
		range_word_t want;
		logic reg_idx;
		logic [DataW-1:0] value;
	} stim_row_t;

	localparam range_word_t AFTER_RESET = '0;
	localparam range_word_t OUT_OF_RANGE = '{1'b0, 13'd0, 10'd0, 1'b1, 1'b0};

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;
	logic tick_valid = 1'b0;
	logic tick_stall;
	logic echo_level = 1'b0;
	logic start_request = 1'b0;
	logic ready_ack = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic trigger_out;
	logic [MmW-1:0] range_mm;
	logic [CmW-1:0] range_cm;
	logic result_ready;
	logic measuring;

	ultrasonic_echo_ranger_core dut (.*);

	logic [CountW-1:0] timeout_cfg = TIMEOUT_RST;
	logic [TrigW-1:0] width_cfg = TRIG_WIDTH_RST;
	logic echo_seen = 1'b0;
	logic timing = 1'b0;
	logic ready_held = 1'b0;
	logic [CountW-1:0] echo_ticks = '0;
	logic [MmW-1:0] held_mm = '0;
	logic [TrigW-1:0] pulse_ticks = '0;

	range_word_t range_words_due[$];
	stim_row_t dir_rows[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [MmW-1:0] mm_from_ticks(logic [CountW-1:0] t);
		int unsigned d;
		if (t >= timeout_cfg) return '0;
		d = (32'(t) * 5 + 14) / 29;
		return (d > MM_CEIL) ? MmW'(MM_CEIL) : d[MmW-1:0];
	endfunction

	function automatic range_word_t advance_ranger(logic e, logic s, logic a);
		range_word_t w;
		logic fresh;
		fresh = 1'b0;
		if (s) pulse_ticks = width_cfg;
		w.trig = (pulse_ticks != 0);
		if (pulse_ticks != 0) pulse_ticks = pulse_ticks - 1'b1;
		if (e && !echo_seen) begin
			echo_ticks = '0;
			timing = 1'b1;
		end else if (timing) begin
			if (echo_ticks != COUNT_MAX) echo_ticks = echo_ticks + 1'b1;
			if (!e) begin
				timing = 1'b0;
				held_mm = mm_from_ticks(echo_ticks);
				fresh = 1'b1;
			end
		end
		echo_seen = e;
		if (fresh) ready_held = 1'b1;
		w.rdy = ready_held;
		if (!fresh && a) ready_held = 1'b0;
		w.mm = held_mm;
		w.cm = CmW'((32'(held_mm) + 5) / 10);
		w.meas = timing;
		return w;
	endfunction

	function automatic stim_row_t tick_row(logic e, logic s, logic a, int reps,
			bit typed = 1'b0, range_word_t want = '0);
		stim_row_t r;
		r = '{ROW_TICK, e, s, a, reps, typed, want, REG_ECHO_TIMEOUT, '0};
		return r;
	endfunction

	function automatic stim_row_t write_row(logic idx, logic [DataW-1:0] v);
		stim_row_t r;
		r = '{ROW_WRITE, 1'b0, 1'b0, 1'b0, 0, 1'b0, '0, idx, v};
		return r;
	endfunction

	task automatic send_tick(logic e, logic s, logic a, bit typed, range_word_t want);
		range_word_t w;
		while (!calm && $urandom_range(99) < 33) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		echo_level <= e;
		start_request <= s;
		ready_ack <= a;
		do @(posedge clk); while (tick_stall);
		w = advance_ranger(e, s, a);
		range_words_due.push_back(typed ? want : w);
	endtask

	task automatic send_random_tick(logic e);
		send_tick(e, $urandom_range(99) < 4, $urandom_range(99) < 25, 1'b0, '0);
	endtask

	task automatic wait_drained();
		tick_valid <= 1'b0;
		while (range_words_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [DataW-1:0] v);
		wait_drained();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ECHO_TIMEOUT) timeout_cfg = v[CountW-1:0];
		else width_cfg = v[TrigW-1:0];
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin : receiver
		bit hold_given;
		hold_given = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_given) begin
				hold_given = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= !calm && ($urandom_range(99) < 33);
		end
	end

	always @(posedge clk) begin : result_check
		range_word_t want;
		if (result_valid && !result_stall) begin
			if (range_words_due.size() == 0) begin
				$display("%0t ns: result word with none due, expected none actual mm %0d",
					$time, range_mm);
				mismatch_count++;
			end else begin
				want = range_words_due.pop_front();
				check_field("trigger_out", want.trig, trigger_out);
				check_field("range_mm", want.mm, range_mm);
				check_field("range_cm", want.cm, range_cm);
				check_field("result_ready", want.rdy, result_ready);
				check_field("measuring", want.meas, measuring);
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int k;
		int ph;
		int sent;
		int gap;
		int hi;
		int n;
		bit paused;
		logic [CountW-1:0] tmo;
		logic [TrigW-1:0] wid;
		stim_row_t r;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1, 1'b1, AFTER_RESET));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 12));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b1, 1));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 101));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 3));
		dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b1, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b1, 14));
		dir_rows.push_back(write_row(REG_ECHO_TIMEOUT, 32'd65535));
		dir_rows.push_back(write_row(REG_TRIGGER_WIDTH, 32'd255));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 260));
		dir_rows.push_back(write_row(REG_ECHO_TIMEOUT, 32'd1));
		dir_rows.push_back(write_row(REG_TRIGGER_WIDTH, 32'd1));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 1));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1, 1'b1, OUT_OF_RANGE));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b1, 2));
		dir_rows.push_back(write_row(REG_ECHO_TIMEOUT, 32'd0));
		dir_rows.push_back(write_row(REG_TRIGGER_WIDTH, 32'd0));
		dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 5));
		dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1, 1'b1, OUT_OF_RANGE));
		dir_rows.push_back(tick_row(1'b0, 1'b1, 1'b0, 1, 1'b1, OUT_OF_RANGE));

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.kind == ROW_WRITE) begin
				write_reg(r.reg_idx, r.value);
			end else begin
				for (k = 0; k < r.reps; k++)
					send_tick(r.echo, r.start, r.ack, r.typed && (k == r.reps - 1), r.want);
			end
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					tmo = CountW'($urandom_range(20, 300));
					wid = TrigW'($urandom_range(1, 255));
				end
				1: begin
					tmo = TIMEOUT_RST;
					wid = TRIG_WIDTH_RST;
				end
				2: begin
					tmo = 16'd65535;
					wid = 8'd255;
				end
				3: begin
					tmo = 16'd1;
					wid = 8'd1;
				end
				default: begin
					tmo = CountW'($urandom_range(1, 65535));
					wid = TrigW'($urandom_range(1, 255));
				end
			endcase
			write_reg(REG_ECHO_TIMEOUT, 32'(tmo));
			write_reg(REG_TRIGGER_WIDTH, 32'(wid));
			calm = (ph == 1);
			if (ph == 1) hold_req = 1'b1;
			sent = 0;
			paused = 1'b0;
			while (sent < ITEMS_PER_PHASE) begin
				if (ph == 0 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
					paused = 1'b1;
					wait_drained();
				end
				if ($urandom_range(99) < 80) begin
					gap = $urandom_range(0, 8);
					hi = ($urandom_range(9) == 0) ? $urandom_range(60, 400) : $urandom_range(1, 40);
					repeat (gap) send_random_tick(1'b0);
					repeat (hi) send_random_tick(1'b1);
					sent += gap + hi;
				end else begin
					n = $urandom_range(1, 12);
					repeat (n) send_random_tick($urandom_range(1));
					sent += n;
				end
			end
			calm = 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
